// ----- design/fsts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsts_pkg
// Shared types and constants for the fair-share task scheduler.
// ----------------------------------------------------------------------------
package fsts_pkg;

  localparam int NUM_TASKS_DEF    = 128;
  localparam int RUNTIME_BITS_DEF = 32;

  localparam int TID_W   = 8;
  localparam int FUNC_W  = 2;
  localparam int STAT_W  = 3;
  localparam int SLICE_W = 8;
  localparam int CRED_W  = 16;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 16;

  localparam logic [SLICE_W-1:0] SLICE_RESET  = 8'd20;
  localparam logic [CRED_W-1:0]  CREDIT_RESET = 16'd2;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_SLICE  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_CREDIT = 2'd1;

  // event codes
  localparam logic [FUNC_W-1:0] FN_TICK    = 2'd0;
  localparam logic [FUNC_W-1:0] FN_SUSPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FN_RESUME  = 2'd2;
  localparam logic [FUNC_W-1:0] FN_RESET   = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_ID      = 3'd1;
  localparam logic [STAT_W-1:0] ST_MISUSE      = 3'd2;
  localparam logic [STAT_W-1:0] ST_RESUMED_CUR = 3'd3;
  localparam logic [STAT_W-1:0] ST_IDLE        = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } state_t;

  // queued-mark update broadcast to every cell; clear wins over set
  typedef struct packed {
    logic             set_a_en;
    logic [TID_W-1:0] set_a_id;
    logic             set_b_en;
    logic [TID_W-1:0] set_b_id;
    logic             clr_en;
    logic [TID_W-1:0] clr_id;
  } qcmd_t;

endpackage

// ----- design/fsts_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsts_in_if
// Event channel: valid/ready handshake carrying one scheduler event word.
// ----------------------------------------------------------------------------
interface fsts_in_if;
  import fsts_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [TID_W-1:0]  task_id;

  modport source (output valid, func, task_id, input ready);
  modport sink   (input valid, func, task_id, output ready);
endinterface

// ----- design/fsts_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsts_out_if
// Result channel: valid/ready handshake carrying one scheduler result word.
// ----------------------------------------------------------------------------
interface fsts_out_if;
  import fsts_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [TID_W-1:0]  running_task;
  logic              switched;
  logic [TID_W-1:0]  runnable_count;

  modport source (output valid, status, running_task, switched, runnable_count,
                  input ready);
  modport sink   (input valid, status, running_task, switched, runnable_count,
                  output ready);
endinterface

// ----- design/fsts_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsts_cell
// One task slot: holds runtime and queued mark, and folds itself into the
// scan word passed down the chain (least queued key, two runtime lookups and one queued-mark lookup).
// ----------------------------------------------------------------------------
module fsts_cell
  import fsts_pkg::*;
#(
  parameter int RUNTIME_BITS = RUNTIME_BITS_DEF,
  parameter int CELL_ID      = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [RUNTIME_BITS-1:0] floor_rt,
  input  logic [TID_W-1:0]        look_a,
  input  logic [TID_W-1:0]        look_b,
  input  logic                    rt_we,
  input  logic [TID_W-1:0]        rt_id,
  input  logic [RUNTIME_BITS-1:0] rt_val,
  input  qcmd_t                   qcmd,
  input  logic                    in_found,
  input  logic [RUNTIME_BITS-1:0] in_key,
  input  logic [TID_W-1:0]        in_id,
  input  logic [RUNTIME_BITS-1:0] in_rt_a,
  input  logic [RUNTIME_BITS-1:0] in_rt_b,
  input  logic                    in_q_b,
  output logic                    out_found,
  output logic [RUNTIME_BITS-1:0] out_key,
  output logic [TID_W-1:0]        out_id,
  output logic [RUNTIME_BITS-1:0] out_rt_a,
  output logic [RUNTIME_BITS-1:0] out_rt_b,
  output logic                    out_q_b
);

  localparam logic [TID_W-1:0]        MY_ID = TID_W'(CELL_ID);
  localparam logic [RUNTIME_BITS-1:0] SIGN  = {1'b1, {(RUNTIME_BITS-1){1'b0}}};

  logic [RUNTIME_BITS-1:0] runtime;
  logic                    queued;
  logic                    queued_next;
  logic [RUNTIME_BITS-1:0] my_key;
  logic                    take;

  // wrap-safe key: distance from floor, sign-biased
  assign my_key = (runtime - floor_rt) ^ SIGN;
  // strict less keeps the lower id on ties
  assign take   = queued && (!in_found || (my_key < in_key));

  always_comb begin
    queued_next = queued;
    if (qcmd.set_a_en && qcmd.set_a_id == MY_ID) queued_next = 1'b1;
    if (qcmd.set_b_en && qcmd.set_b_id == MY_ID) queued_next = 1'b1;
    if (qcmd.clr_en && qcmd.clr_id == MY_ID) queued_next = 1'b0;
  end

  // task state
  always_ff @(posedge clk) begin
    if (rst) begin
      runtime <= '0;
      queued  <= 1'b0;
    end else begin
      if (rt_we && rt_id == MY_ID) runtime <= rt_val;
      queued <= queued_next;
    end
  end

  // scan word stage
  always_ff @(posedge clk) begin
    out_found <= in_found || queued;
    out_key   <= take ? my_key : in_key;
    out_id    <= take ? MY_ID : in_id;
    out_rt_a  <= (look_a == MY_ID) ? runtime : in_rt_a;
    out_rt_b  <= (look_b == MY_ID) ? runtime : in_rt_b;
    out_q_b   <= (look_b == MY_ID) ? queued : in_q_b;
  end

endmodule

// ----- design/fair_share_task_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fair_share_task_scheduler
// Min-runtime task scheduler built as a chain of per-task cells.
// ----------------------------------------------------------------------------
// Each event is accepted in S_IDLE; in S_SCAN the scan word ripples through
// the chain of task cells (least queued runtime plus the current and addressed
// task lookups); in S_EXEC the update is applied and the result register is
// loaded, once that register is free. One event is in flight at a time; a
// finished result waits in the output register while the next event is
// taken. Configuration writes go through cfg_we/cfg_index/cfg_data and must
// happen while no event is in flight.
module fair_share_task_scheduler
  import fsts_pkg::*;
#(
  parameter int NUM_TASKS    = NUM_TASKS_DEF,
  parameter int RUNTIME_BITS = RUNTIME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_data,
  fsts_in_if.sink            in_ch,
  fsts_out_if.source         out_ch
);

  localparam int RTB   = RUNTIME_BITS;
  localparam int CNT_W = $clog2(NUM_TASKS + 1);
  localparam int SCN_W = $clog2(NUM_TASKS);
  localparam int CW    = (RTB > CRED_W) ? RTB : CRED_W;
  localparam logic [RTB-1:0]   SIGN     = {1'b1, {(RTB-1){1'b0}}};
  localparam logic [SCN_W-1:0] SCAN_END = SCN_W'(NUM_TASKS - 1);
  localparam logic [TID_W:0]   N_IDS    = (TID_W+1)'(NUM_TASKS);

  function automatic logic [RTB-1:0] okey(input logic [RTB-1:0] rt,
                                          input logic [RTB-1:0] fl);
    return (rt - fl) ^ SIGN;
  endfunction

  // config registers
  logic [SLICE_W-1:0] slice_ticks;
  logic [CRED_W-1:0]  wakeup_credit;

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_ticks   <= SLICE_RESET;
      wakeup_credit <= CREDIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLICE:  slice_ticks   <= cfg_data[SLICE_W-1:0];
        REG_CREDIT: wakeup_credit <= cfg_data[CRED_W-1:0];
        default: ;
      endcase
    end
  end

  // scheduler state
  state_t             state, state_next;
  logic [SCN_W-1:0]   scan_cnt;
  logic [FUNC_W-1:0]  ev_func;
  logic [TID_W-1:0]   ev_id;
  logic [TID_W-1:0]   current_task, current_task_next;
  logic [CNT_W-1:0]   runnable_total, runnable_total_next;
  logic [RTB-1:0]     floor_rt, floor_rt_next;
  logic [SLICE_W-1:0] slice_count, slice_count_next;

  // output register
  logic               o_valid;
  logic [STAT_W-1:0]  o_status, status_next;
  logic [TID_W-1:0]   o_task;
  logic               o_sw, sw_next;
  logic [TID_W-1:0]   o_count;

  logic in_fire, out_free, exec_fire;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_free  = !o_valid || out_ch.ready;
  assign exec_fire = (state == S_EXEC) && out_free;
  assign in_ch.ready = (state == S_IDLE);

  // chain wiring
  logic           ch_found [NUM_TASKS+1];
  logic [RTB-1:0] ch_key   [NUM_TASKS+1];
  logic [TID_W-1:0] ch_id  [NUM_TASKS+1];
  logic [RTB-1:0] ch_rt_a  [NUM_TASKS+1];
  logic [RTB-1:0] ch_rt_b  [NUM_TASKS+1];
  logic           ch_q_b   [NUM_TASKS+1];

  assign ch_found[0] = 1'b0;
  assign ch_key[0]   = '0;
  assign ch_id[0]    = '0;
  assign ch_rt_a[0]  = '0;
  assign ch_rt_b[0]  = '0;
  assign ch_q_b[0]   = 1'b0;

  logic           rt_we;
  logic [TID_W-1:0] rt_id;
  logic [RTB-1:0] rt_val;
  qcmd_t          qcmd;
  qcmd_t          qcmd_raw;
  logic           rt_we_raw;

  assign rt_we = rt_we_raw && exec_fire;
  always_comb begin
    qcmd          = qcmd_raw;
    qcmd.set_a_en = qcmd_raw.set_a_en && exec_fire;
    qcmd.set_b_en = qcmd_raw.set_b_en && exec_fire;
    qcmd.clr_en   = qcmd_raw.clr_en && exec_fire;
  end

  for (genvar g = 0; g < NUM_TASKS; g++) begin : g_cell
    fsts_cell #(.RUNTIME_BITS(RTB), .CELL_ID(g)) u_cell (
      .clk, .rst,
      .floor_rt (floor_rt),
      .look_a   (current_task),
      .look_b   (ev_id),
      .rt_we    (rt_we),
      .rt_id    (rt_id),
      .rt_val   (rt_val),
      .qcmd     (qcmd),
      .in_found (ch_found[g]),
      .in_key   (ch_key[g]),
      .in_id    (ch_id[g]),
      .in_rt_a  (ch_rt_a[g]),
      .in_rt_b  (ch_rt_b[g]),
      .in_q_b   (ch_q_b[g]),
      .out_found(ch_found[g+1]),
      .out_key  (ch_key[g+1]),
      .out_id   (ch_id[g+1]),
      .out_rt_a (ch_rt_a[g+1]),
      .out_rt_b (ch_rt_b[g+1]),
      .out_q_b  (ch_q_b[g+1])
    );
  end

  // scan results
  logic           s_found, q_b;
  logic [RTB-1:0] best_key, rt_cur, rt_b;
  logic [TID_W-1:0] best_id;
  assign s_found  = ch_found[NUM_TASKS];
  assign best_key = ch_key[NUM_TASKS];
  assign best_id  = ch_id[NUM_TASKS];
  assign rt_cur   = ch_rt_a[NUM_TASKS];
  assign rt_b     = ch_rt_b[NUM_TASKS];
  assign q_b      = ch_q_b[NUM_TASKS];

  // event evaluation
  logic [RTB-1:0]     rt_inc, base, rt_clamp, cand_key;
  logic [CW-1:0]      floor_ext, cred_ext;
  logic [SLICE_W-1:0] slice_inc;
  logic [TID_W-1:0]   cand_id;
  logic               bad_id, is_cur, pick_new;

  always_comb begin
    rt_inc    = rt_cur + 1'b1;
    slice_inc = slice_count + 1'b1;
    floor_ext = CW'(floor_rt);
    cred_ext  = CW'(wakeup_credit);
    base      = (floor_ext >= cred_ext) ? RTB'(floor_ext - cred_ext) : floor_rt;
    rt_clamp  = (okey(rt_b, floor_rt) < okey(base, floor_rt)) ? base : rt_b;
    bad_id    = {1'b0, ev_id} >= N_IDS;
    is_cur    = (runnable_total != '0) && (ev_id == current_task);
    pick_new  = !s_found || (okey(rt_clamp, floor_rt) < best_key) ||
                ((okey(rt_clamp, floor_rt) == best_key) && (ev_id < best_id));
    cand_key  = pick_new ? okey(rt_clamp, floor_rt) : best_key;
    cand_id   = pick_new ? ev_id : best_id;

    status_next         = ST_OK;
    sw_next             = 1'b0;
    current_task_next   = current_task;
    runnable_total_next = runnable_total;
    floor_rt_next       = floor_rt;
    slice_count_next    = slice_count;
    rt_we_raw           = 1'b0;
    rt_id               = ev_id;
    rt_val              = '0;
    qcmd_raw            = '0;

    if (ev_func == FN_TICK) begin
      if (runnable_total == '0) begin
        status_next = ST_IDLE;
      end else begin
        rt_we_raw        = 1'b1;
        rt_id            = current_task;
        rt_val           = rt_inc;
        slice_count_next = slice_inc;
        if (slice_inc >= slice_ticks) begin
          slice_count_next = '0;
          if ((runnable_total >= CNT_W'(2)) && s_found &&
              (okey(rt_inc, floor_rt) > best_key)) begin
            floor_rt_next     = (best_key ^ SIGN) + floor_rt;
            qcmd_raw.set_a_en = 1'b1;
            qcmd_raw.set_a_id = current_task;
            qcmd_raw.clr_en   = 1'b1;
            qcmd_raw.clr_id   = best_id;
            current_task_next = best_id;
            sw_next           = 1'b1;
          end
        end
      end
    end else if (bad_id) begin
      status_next = ST_BAD_ID;
    end else if (ev_func == FN_SUSPEND) begin
      if (is_cur) begin
        if (s_found) begin
          qcmd_raw.clr_en   = 1'b1;
          qcmd_raw.clr_id   = best_id;
          current_task_next = best_id;
          sw_next           = 1'b1;
        end
        runnable_total_next = runnable_total - 1'b1;
      end else if (q_b) begin
        qcmd_raw.clr_en = 1'b1;
        qcmd_raw.clr_id = ev_id;
        if (runnable_total != '0) runnable_total_next = runnable_total - 1'b1;
      end else begin
        status_next = ST_MISUSE;
      end
    end else if (ev_func == FN_RESUME) begin
      if (q_b) begin
        status_next = ST_MISUSE;
      end else begin
        rt_we_raw = 1'b1;
        rt_val    = rt_clamp;
        if (runnable_total == '0) begin
          floor_rt_next       = rt_clamp;
          current_task_next   = ev_id;
          runnable_total_next = CNT_W'(1);
        end else if (ev_id == current_task) begin
          status_next = ST_RESUMED_CUR;
        end else begin
          qcmd_raw.set_a_en   = 1'b1;
          qcmd_raw.set_a_id   = ev_id;
          runnable_total_next = runnable_total + 1'b1;
          if (okey(rt_cur, floor_rt) > cand_key) begin
            qcmd_raw.set_b_en = 1'b1;
            qcmd_raw.set_b_id = current_task;
            qcmd_raw.clr_en   = 1'b1;
            qcmd_raw.clr_id   = cand_id;
            current_task_next = cand_id;
            sw_next           = 1'b1;
          end
        end
      end
    end else begin
      rt_we_raw = 1'b1;
      rt_val    = '0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_fire) state_next = S_SCAN;
      S_SCAN: if (scan_cnt == SCAN_END) state_next = S_EXEC;
      S_EXEC: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ev_func <= in_ch.func;
      ev_id   <= in_ch.task_id;
    end
    if (state == S_SCAN) scan_cnt <= scan_cnt + 1'b1;
    else                 scan_cnt <= '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_task   <= '0;
      runnable_total <= '0;
      floor_rt       <= '0;
      slice_count    <= '0;
    end else if (exec_fire) begin
      current_task   <= current_task_next;
      runnable_total <= runnable_total_next;
      floor_rt       <= floor_rt_next;
      slice_count    <= slice_count_next;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (exec_fire) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      o_status <= status_next;
      o_task   <= current_task_next;
      o_sw     <= sw_next;
      o_count  <= TID_W'(runnable_total_next);
    end
  end

  assign out_ch.valid          = o_valid;
  assign out_ch.status         = o_status;
  assign out_ch.running_task   = o_task;
  assign out_ch.switched       = o_sw;
  assign out_ch.runnable_count = o_count;

  // checks
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    runnable_total <= CNT_W'(NUM_TASKS))
    else $error("runnable count exceeds task count");

  a_cur_in_range: assert property (@(posedge clk) disable iff (rst)
    (runnable_total != '0) |-> ({1'b0, current_task} < N_IDS))
    else $error("current task out of range");

  a_switch_ok: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_sw) |-> (o_status == ST_OK))
    else $error("switch reported with error status");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == S_SCAN))
    else $error("accepted word did not start a scan");

endmodule

// ----- tb/tb_fair_share_task_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fair_share_task_scheduler
// Self-checking bench for the fair-share task scheduler: a directed opener and
// random event streams over several slice/credit settings, checked word by
// word against a cycle-free scheduler model held in the bench.
// ----------------------------------------------------------------------------
module tb_fair_share_task_scheduler;
  import fsts_pkg::*;

  localparam int NT         = NUM_TASKS_DEF;
  localparam int RB         = RUNTIME_BITS_DEF;
  localparam int EVENT_LAT  = NT + 12;
  localparam int DOG_LIMIT  = 20000;
  localparam logic [CIDX_W-1:0] REG_SPARE = 2'd2;
  localparam logic [CIDX_W-1:0] REG_TOP   = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TID_W-1:0]  id;
  } event_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [TID_W-1:0]  running;
    logic              switched;
    logic [TID_W-1:0]  count;
  } sched_res_t;

  logic clk, rst;
  logic cfg_we;
  logic [CIDX_W-1:0]  cfg_index;
  logic [CDATA_W-1:0] cfg_data;

  fsts_in_if  in_ch ();
  fsts_out_if out_ch ();

  fair_share_task_scheduler dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  // scheduler model state
  logic [RB-1:0]      m_rt [NT];
  bit                 m_queued [NT];
  logic [TID_W-1:0]   m_cur;
  logic [TID_W-1:0]   m_total;
  logic [RB-1:0]      m_floor;
  logic [SLICE_W-1:0] m_slice_cnt;
  logic [SLICE_W-1:0] m_slice_ticks;
  logic [CRED_W-1:0]  m_credit;

  event_t     event_q[$];
  sched_res_t sched_exp_q[$];
  int errors = 0, events_in = 0, results_out = 0, switches = 0;
  int status_seen [8];
  bit in_busy = 0;
  int send_gap = 0, hold = 0, dog = 0;
  bit long_hold_done = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // wrap-safe order key relative to the floor
  function automatic logic [RB-1:0] order_key(logic [RB-1:0] rt);
    return (rt - m_floor) ^ {1'b1, {(RB-1){1'b0}}};
  endfunction

  function automatic bit least_queued(output int who);
    bit found;
    logic [RB-1:0] best, k;
    found = 0;
    best = '0;
    who = 0;
    for (int i = 0; i < NT; i++) begin
      if (m_queued[i]) begin
        k = order_key(m_rt[i]);
        if (!found || k < best) begin
          best = k;
          who = i;
          found = 1;
        end
      end
    end
    return found;
  endfunction

  function automatic void sched_config(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] val);
    if (idx == REG_SLICE) m_slice_ticks = val[SLICE_W-1:0];
    else if (idx == REG_CREDIT) m_credit = val;
  endfunction

  // advance the model by one event word and queue its result
  function automatic void sched_predict(event_t ev);
    sched_res_t r;
    int nxt, c;
    logic [RB-1:0] base;
    logic [SLICE_W-1:0] lim;
    r = '0;
    r.status = ST_OK;
    c = m_cur % NT;
    if (ev.func == FN_TICK) begin
      if (m_total == 0) begin
        r.status = ST_IDLE;
      end else begin
        m_rt[c] = m_rt[c] + 1'b1;
        m_slice_cnt = m_slice_cnt + 1'b1;
        lim = m_slice_ticks;
        if (m_slice_cnt >= lim) begin
          m_slice_cnt = '0;
          if (m_total >= 2 && least_queued(nxt) &&
              order_key(m_rt[c]) > order_key(m_rt[nxt])) begin
            m_floor = m_rt[nxt];
            m_queued[c] = 1;
            m_queued[nxt] = 0;
            m_cur = TID_W'(nxt);
            r.switched = 1;
          end
        end
      end
    end else if (ev.id >= NT) begin
      r.status = ST_BAD_ID;
    end else if (ev.func == FN_SUSPEND) begin
      if (m_total > 0 && ev.id == m_cur) begin
        if (least_queued(nxt)) begin
          m_queued[nxt] = 0;
          m_cur = TID_W'(nxt);
          r.switched = 1;
        end
        m_total = m_total - 1'b1;
      end else if (m_queued[ev.id]) begin
        m_queued[ev.id] = 0;
        if (m_total > 0) m_total = m_total - 1'b1;
      end else begin
        r.status = ST_MISUSE;
      end
    end else if (ev.func == FN_RESUME) begin
      if (m_queued[ev.id]) begin
        r.status = ST_MISUSE;
      end else begin
        // wakeup clamp
        base = m_floor;
        if (m_floor >= RB'(m_credit)) base = m_floor - RB'(m_credit);
        if (order_key(m_rt[ev.id]) < order_key(base)) m_rt[ev.id] = base;
        if (m_total == 0) begin
          m_floor = m_rt[ev.id];
          m_cur = ev.id;
          m_total = 8'd1;
        end else if (ev.id == m_cur) begin
          r.status = ST_RESUMED_CUR;
        end else begin
          m_queued[ev.id] = 1;
          m_total = m_total + 1'b1;
          if (least_queued(nxt) && order_key(m_rt[c]) > order_key(m_rt[nxt])) begin
            m_queued[c] = 1;
            m_queued[nxt] = 0;
            m_cur = TID_W'(nxt);
            r.switched = 1;
          end
        end
      end
    end else begin
      m_rt[ev.id] = '0;
    end
    r.running = m_cur;
    r.count = m_total;
    sched_exp_q.push_back(r);
  endfunction

  function automatic void push_event(logic [FUNC_W-1:0] f, logic [TID_W-1:0] id);
    event_t ev;
    ev.func = f;
    ev.id = id;
    event_q.push_back(ev);
  endfunction

  // random event with mostly small ids so tasks collide and compete
  function automatic void push_random_event();
    int p, q;
    logic [FUNC_W-1:0] f;
    logic [TID_W-1:0] id;
    p = $urandom_range(99);
    q = $urandom_range(99);
    if (p < 45) f = FN_TICK;
    else if (p < 72) f = FN_RESUME;
    else if (p < 93) f = FN_SUSPEND;
    else f = FN_RESET;
    if (q < 85) id = TID_W'($urandom_range(7));
    else if (q < 95) id = TID_W'($urandom_range(NT - 1));
    else id = TID_W'($urandom_range(255, NT));
    push_event(f, id);
  endfunction

  // random gap before the next offered word
  function automatic void p_gap();
    int p;
    p = $urandom_range(99);
    if (p < 65) send_gap = 0;
    else if (p < 95) send_gap = $urandom_range(5, 1);
    else send_gap = $urandom_range(300, 20);
  endfunction

  task automatic wait_idle();
    while (event_q.size() != 0 || in_busy || sched_exp_q.size() != 0) @(posedge clk);
    repeat (EVENT_LAT) @(posedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    sched_config(idx, val);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) push_random_event();
    wait_idle();
  endtask

  // sender: one word offered at a time, random gaps between words
  always @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      sched_predict(event_t'({in_ch.func, in_ch.task_id}));
      events_in++;
      in_busy = 0;
      p_gap();
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 0;
    end else if (!in_busy) begin
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 0;
      end else if (event_q.size() != 0) begin
        event_t ev;
        ev = event_q.pop_front();
        in_ch.func <= ev.func;
        in_ch.task_id <= ev.id;
        in_ch.valid <= 1;
        in_busy = 1;
      end else begin
        in_ch.valid <= 0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off mid-run
  always @(negedge clk) begin
    int p;
    if (rst) begin
      out_ch.ready <= 0;
    end else if (hold > 0) begin
      hold--;
      out_ch.ready <= 0;
    end else if (!long_hold_done && events_in >= 300) begin
      long_hold_done = 1;
      hold = 1500;
      out_ch.ready <= 0;
    end else begin
      p = $urandom_range(99);
      if (p < 70) out_ch.ready <= 1;
      else if (p < 97) begin
        out_ch.ready <= 0;
        hold = $urandom_range(4);
      end else begin
        out_ch.ready <= 0;
        hold = $urandom_range(300, 20);
      end
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      sched_res_t got, want;
      got.status = out_ch.status;
      got.running = out_ch.running_task;
      got.switched = out_ch.switched;
      got.count = out_ch.runnable_count;
      results_out++;
      if (sched_exp_q.size() == 0) begin
        $display("%0t: unexpected result word %p", $time, got);
        errors++;
      end else begin
        want = sched_exp_q.pop_front();
        status_seen[want.status]++;
        if (want.switched) switches++;
        if (got.status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.running !== want.running) begin
          $display("%0t: running_task exp %0d got %0d", $time, want.running, got.running);
          errors++;
        end
        if (got.switched !== want.switched) begin
          $display("%0t: switched exp %0d got %0d", $time, want.switched, got.switched);
          errors++;
        end
        if (got.count !== want.count) begin
          $display("%0t: runnable_count exp %0d got %0d", $time, want.count, got.count);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) dog <= 0;
    else dog <= dog + 1;
    if (dog >= DOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = REG_SLICE;
    cfg_data = '0;
    in_ch.valid = 0;
    in_ch.func = FN_TICK;
    in_ch.task_id = '0;
    out_ch.ready = 0;
    for (int i = 0; i < NT; i++) begin
      m_rt[i] = '0;
      m_queued[i] = 0;
    end
    m_cur = '0;
    m_total = '0;
    m_floor = '0;
    m_slice_cnt = '0;
    m_slice_ticks = SLICE_RESET;
    m_credit = CREDIT_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed opener under reset settings
    push_event(FN_TICK, 8'd0);
    push_event(FN_SUSPEND, 8'd200);
    push_event(FN_RESUME, TID_W'(NT));
    push_event(FN_RESET, 8'd255);
    push_event(FN_SUSPEND, 8'd3);
    push_event(FN_RESUME, 8'd0);
    push_event(FN_RESUME, 8'd0);
    push_event(FN_RESUME, 8'd1);
    push_event(FN_RESUME, 8'd1);
    push_event(FN_RESET, 8'd0);
    for (int i = 0; i < 4; i++) push_event(FN_TICK, 8'd0);
    push_event(FN_SUSPEND, 8'd1);
    push_event(FN_SUSPEND, 8'd0);
    push_event(FN_RESUME, 8'd2);
    push_event(FN_RESUME, 8'd3);
    push_event(FN_SUSPEND, 8'd2);
    push_event(FN_RESUME, TID_W'(NT - 1));
    push_event(FN_TICK, 8'd0);
    wait_idle();
    random_phase(200);

    write_reg(REG_SLICE, 16'd1);
    write_reg(REG_CREDIT, 16'd0);
    random_phase(200);

    // zero slice acts like one; spare indexes must be ignored
    write_reg(REG_SLICE, 16'd0);
    write_reg(REG_CREDIT, 16'hFFFF);
    write_reg(REG_SPARE, 16'h5A5A);
    write_reg(REG_TOP, 16'hFFFF);
    random_phase(200);

    write_reg(REG_SLICE, 16'd255);
    write_reg(REG_CREDIT, 16'd7);
    random_phase(200);

    write_reg(REG_SLICE, 16'd3);
    write_reg(REG_CREDIT, 16'd1);
    random_phase(200);

    $display("events %0d, results %0d, switches %0d", events_in, results_out, switches);
    $display("status ok %0d bad_id %0d misuse %0d resumed_cur %0d idle %0d",
             status_seen[ST_OK], status_seen[ST_BAD_ID], status_seen[ST_MISUSE],
             status_seen[ST_RESUMED_CUR], status_seen[ST_IDLE]);
    if (errors == 0 && sched_exp_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
